>>> hdl/dbra_pkg.sv
// dbra_pkg: shared types and constants for the deadband report aggregator
// no dependencies

`timescale 1ns / 1ps

package dbra_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned TOTAL_W = 48;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned IDX_W   = 2;

  // register index, taken from paddr[3:2]
  localparam logic [IDX_W-1:0] REG_ABSOLUTE_MODE    = 2'd0;
  localparam logic [IDX_W-1:0] REG_CHANGE_THRESHOLD = 2'd1;
  localparam logic [IDX_W-1:0] REG_RATE_LIMIT       = 2'd2;

  // input action codes
  localparam logic ACT_SAMPLE       = 1'b0;
  localparam logic ACT_WINDOW_RESET = 1'b1;

  // percent test scale: 100 in Q16.16
  localparam logic [PROD_W-1:0] PCT_SCALE = 64'd6553600;

  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = 48'sh8000_0000_0000;
  localparam logic [DATA_W-1:0]         COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic                      report_valid;
    logic signed [DATA_W-1:0]  report_value;
    logic signed [DATA_W-1:0]  window_min;
    logic signed [DATA_W-1:0]  window_max;
    logic signed [TOTAL_W-1:0] window_total;
    logic [DATA_W-1:0]         sample_count;
  } result_t;

endpackage

>>> hdl/deadband_report_aggregator_core.sv
// deadband_report_aggregator_core: report-by-exception with deadband and rate limit
// depends on dbra_pkg
//
// input channel: in_valid / in_stall carries a request (action, sample, tick);
// action selects a new sample or a statistics window reset.
// output channel: out_valid / out_stall carries one result per request with the
// report flag, reported value and the window min, max, total and count.
// a request is taken when valid is high and stall is low at a rising edge.
// out_valid rises once an accepted request has passed the input register,
// then the statistics and report decision in one pass into the result register.
// throughput is one request per cycle while out_stall is low; the per-request state
// loop (last reported value, tick and window statistics) closes in that single pass.
// when the receiver stalls, the result register holds and one more request
// waits in the input register; in_stall rises only when both are full.
// configuration goes through an APB-style port, pready is always high;
// registers: absolute mode at 0x0, change threshold at 0x4, rate limit at 0x8.
// rst_n is synchronous active low: it clears both channels, the statistics,
// the last reported value and tick, and all configuration registers.

`timescale 1ns / 1ps

module deadband_report_aggregator_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_action,
  input  logic signed [dbra_pkg::DATA_W-1:0]   in_sample_value,
  input  logic [dbra_pkg::DATA_W-1:0]          in_now_tick,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_report_valid,
  output logic signed [dbra_pkg::DATA_W-1:0]   out_report_value,
  output logic signed [dbra_pkg::DATA_W-1:0]   out_window_min,
  output logic signed [dbra_pkg::DATA_W-1:0]   out_window_max,
  output logic signed [dbra_pkg::TOTAL_W-1:0]  out_window_total,
  output logic [dbra_pkg::DATA_W-1:0]          out_sample_count,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dbra_pkg::ADDR_W-1:0]          paddr,
  input  logic [dbra_pkg::DATA_W-1:0]          pwdata,
  output logic [dbra_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);

  localparam int unsigned W  = dbra_pkg::DATA_W;
  localparam int unsigned TW = dbra_pkg::TOTAL_W;
  localparam int unsigned PW = dbra_pkg::PROD_W;

  // configuration
  logic         absolute_mode_r;
  logic [W-1:0] change_threshold_r;
  logic [W-1:0] gap_limit_r;
  logic         cfg_write;
  logic [dbra_pkg::IDX_W-1:0] cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      absolute_mode_r    <= 1'b0;
      change_threshold_r <= '0;
      gap_limit_r        <= '0;
    end else if (cfg_write) begin
      case (cfg_idx)
        dbra_pkg::REG_ABSOLUTE_MODE:    absolute_mode_r    <= pwdata[0];
        dbra_pkg::REG_CHANGE_THRESHOLD: change_threshold_r <= pwdata;
        dbra_pkg::REG_RATE_LIMIT:       gap_limit_r        <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dbra_pkg::REG_ABSOLUTE_MODE:    prdata = {{(W-1){1'b0}}, absolute_mode_r};
      dbra_pkg::REG_CHANGE_THRESHOLD: prdata = change_threshold_r;
      dbra_pkg::REG_RATE_LIMIT:       prdata = gap_limit_r;
      default:                        prdata = '0;
    endcase
  end

  // input register
  logic                in_valid_r, in_valid_nxt;
  logic                in_action_r;
  logic signed [W-1:0] in_sample_r;
  logic [W-1:0]        in_tick_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;
  logic                process;
  logic                in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign process  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (process) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (process) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_action_r <= in_action;
      in_sample_r <= in_sample_value;
      in_tick_r   <= in_now_tick;
    end
  end

  // window and report state
  logic signed [W-1:0]  min_r, min_nxt;
  logic signed [W-1:0]  max_r, max_nxt;
  logic signed [TW-1:0] sum_r, sum_nxt;
  logic [W-1:0]         count_r, count_nxt;
  logic signed [W-1:0]  current_r, current_nxt;
  logic signed [W-1:0]  last_rep_r, last_rep_nxt;
  logic [W-1:0]         last_tick_r, last_tick_nxt;

  logic signed [TW:0]   sum_wide;
  logic signed [W:0]    diff;
  logic [W:0]           diff_neg;
  logic [W-1:0]         delta;
  logic [W:0]           last_neg;
  logic [W-1:0]         abs_last;
  logic [PW-1:0]        pct_lhs;
  logic [PW-1:0]        pct_rhs;
  logic [W-1:0]         tick_diff;
  logic                 change_ok;
  logic                 report;
  dbra_pkg::result_t    res_nxt, res_r;

  always_comb begin
    sum_wide  = {sum_r[TW-1], sum_r} + {{(TW-W+1){in_sample_r[W-1]}}, in_sample_r};
    diff      = {last_rep_r[W-1], last_rep_r} - {in_sample_r[W-1], in_sample_r};
    diff_neg  = -diff;
    delta     = diff[W] ? diff_neg[W-1:0] : diff[W-1:0];
    last_neg  = -{last_rep_r[W-1], last_rep_r};
    abs_last  = last_rep_r[W-1] ? last_neg[W-1:0] : last_rep_r;
    pct_lhs   = {{(PW-W){1'b0}}, delta} * dbra_pkg::PCT_SCALE;
    pct_rhs   = {{(PW-W){1'b0}}, change_threshold_r} * {{(PW-W){1'b0}}, abs_last};
    tick_diff = in_tick_r - last_tick_r;

    if (absolute_mode_r) begin
      change_ok = delta > change_threshold_r;
    end else begin
      change_ok = pct_lhs > pct_rhs;
    end
    report = (in_action_r == dbra_pkg::ACT_SAMPLE) && (change_threshold_r != '0) &&
             change_ok && (tick_diff > gap_limit_r);

    min_nxt       = min_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    current_nxt   = current_r;
    last_rep_nxt  = last_rep_r;
    last_tick_nxt = last_tick_r;

    case (in_action_r)
      dbra_pkg::ACT_WINDOW_RESET: begin
        sum_nxt       = '0;
        count_nxt     = '0;
        last_rep_nxt  = current_r;
        last_tick_nxt = in_tick_r;
      end
      default: begin
        if (count_r == '0) begin
          min_nxt = in_sample_r;
          max_nxt = in_sample_r;
        end else begin
          if (in_sample_r < min_r) min_nxt = in_sample_r;
          if (in_sample_r > max_r) max_nxt = in_sample_r;
        end
        if (sum_wide[TW] != sum_wide[TW-1]) begin
          sum_nxt = sum_wide[TW] ? dbra_pkg::TOTAL_MIN : dbra_pkg::TOTAL_MAX;
        end else begin
          sum_nxt = sum_wide[TW-1:0];
        end
        if (count_r != dbra_pkg::COUNT_MAX) count_nxt = count_r + 1'b1;
        current_nxt = in_sample_r;
        if (report) begin
          last_rep_nxt  = in_sample_r;
          last_tick_nxt = in_tick_r;
        end
      end
    endcase

    res_nxt.report_valid = report;
    res_nxt.report_value = report ? in_sample_r : '0;
    res_nxt.window_min   = min_nxt;
    res_nxt.window_max   = max_nxt;
    res_nxt.window_total = sum_nxt;
    res_nxt.sample_count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= '0;
      max_r       <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      current_r   <= '0;
      last_rep_r  <= '0;
      last_tick_r <= '0;
    end else if (process) begin
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      current_r   <= current_nxt;
      last_rep_r  <= last_rep_nxt;
      last_tick_r <= last_tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_report_valid = res_r.report_valid;
  assign out_report_value = res_r.report_value;
  assign out_window_min   = res_r.window_min;
  assign out_window_max   = res_r.window_max;
  assign out_window_total = res_r.window_total;
  assign out_sample_count = res_r.sample_count;

`ifndef SYNTHESIS
  a_no_value_without_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.report_valid |-> res_r.report_value == '0)
    else $error("report value nonzero without report");

  a_empty_window_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.sample_count == '0 |-> res_r.window_total == '0)
    else $error("empty window with nonzero total");

  a_min_not_above_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.sample_count != '0 |-> res_r.window_min <= res_r.window_max)
    else $error("window min above max");

  a_report_updates_last: assert property (@(posedge clk) disable iff (!rst_n)
    process && report |=> last_rep_r == $past(in_sample_r) && last_tick_r == $past(in_tick_r))
    else $error("report did not update last reported state");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r)
    else $error("input stalled with free space");
`endif

endmodule

>>> bench/deadband_report_aggregator_core_test.sv
// deadband_report_aggregator_core_test: self-checking bench for the deadband report aggregator
// drives requests, register writes, output stalls; checks results vs a predictor or fixed values
// depends on dbra_pkg and deadband_report_aggregator_core

`timescale 1ns / 1ps

module deadband_report_aggregator_core_test;

  localparam int              IDLE_LIMIT = 2000;
  localparam int              MAX_SHOWN  = 10;
  localparam longint          SUM_HI     = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint          SUM_LO     = -SUM_HI - 1;
  localparam longint unsigned PCT_Q16    = 64'd6553600;

  typedef enum logic {ROW_REQUEST, ROW_REGISTER} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic                       act;
    logic [31:0]                value;
    logic [31:0]                tick;
    logic [dbra_pkg::IDX_W-1:0] reg_idx;
    bit                         typed;
    dbra_pkg::result_t          want;
  } plan_row_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic                                in_action = dbra_pkg::ACT_SAMPLE;
  logic signed [dbra_pkg::DATA_W-1:0]  in_sample_value = '0;
  logic [dbra_pkg::DATA_W-1:0]         in_now_tick = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic                                out_report_valid;
  logic signed [dbra_pkg::DATA_W-1:0]  out_report_value;
  logic signed [dbra_pkg::DATA_W-1:0]  out_window_min;
  logic signed [dbra_pkg::DATA_W-1:0]  out_window_max;
  logic signed [dbra_pkg::TOTAL_W-1:0] out_window_total;
  logic [dbra_pkg::DATA_W-1:0]         out_sample_count;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [dbra_pkg::ADDR_W-1:0]         paddr = '0;
  logic [dbra_pkg::DATA_W-1:0]         pwdata = '0;
  logic [dbra_pkg::DATA_W-1:0]         prdata;
  logic                                pready;

  // mirror of the block state and registers
  bit                        mode_absolute = 1'b0;
  logic [31:0]               deadband = '0;
  logic [31:0]               min_gap = '0;
  logic signed [31:0]        win_min = '0;
  logic signed [31:0]        win_max = '0;
  logic signed [47:0]        win_sum = '0;
  logic [31:0]               win_count = '0;
  logic signed [31:0]        latest_sample = '0;
  logic signed [31:0]        prev_value = '0;
  logic [31:0]               prev_tick = '0;

  dbra_pkg::result_t         window_results_due[$];
  plan_row_t                 plan[$];
  int                        mismatches = 0;
  int                        burst_left = 0;
  int                        idle_cycles = 0;
  int                        stall_left = 0;
  int                        stall_mode = 0;

  deadband_report_aggregator_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_sample_value  (in_sample_value),
    .in_now_tick      (in_now_tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_report_valid (out_report_valid),
    .out_report_value (out_report_value),
    .out_window_min   (out_window_min),
    .out_window_max   (out_window_max),
    .out_window_total (out_window_total),
    .out_sample_count (out_sample_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // updates the window statistics and decides the report for one request
  function automatic dbra_pkg::result_t next_window_result(input logic act,
                                                           input logic signed [31:0] v,
                                                           input logic [31:0] tick);
    dbra_pkg::result_t r;
    longint            span;
    longint            sum_next;
    longint unsigned   mag;
    logic [31:0]       elapsed;
    bit                moved;
    r = '0;
    if (act == dbra_pkg::ACT_WINDOW_RESET) begin
      win_sum = '0;
      win_count = '0;
      prev_value = latest_sample;
      prev_tick = tick;
    end else begin
      if (win_count == 0) begin
        win_min = v;
        win_max = v;
      end else begin
        if (v < win_min) win_min = v;
        if (v > win_max) win_max = v;
      end
      sum_next = longint'(win_sum) + longint'(v);
      if (sum_next > SUM_HI) sum_next = SUM_HI;
      if (sum_next < SUM_LO) sum_next = SUM_LO;
      win_sum = sum_next[47:0];
      if (win_count != 32'hFFFF_FFFF) win_count = win_count + 1;
      latest_sample = v;
      span = longint'(prev_value) - longint'(v);
      if (span < 0) span = -span;
      mag = (prev_value < 0) ? 64'(-longint'(prev_value)) : 64'(longint'(prev_value));
      if (deadband == 0) moved = 1'b0;
      else if (mode_absolute) moved = 64'(span) > 64'(deadband);
      else moved = 64'(span) * PCT_Q16 > 64'(deadband) * mag;
      elapsed = tick - prev_tick;
      if (moved && elapsed > min_gap) begin
        r.report_valid = 1'b1;
        r.report_value = v;
        prev_value = v;
        prev_tick = tick;
      end
    end
    r.window_min = win_min;
    r.window_max = win_max;
    r.window_total = win_sum;
    r.sample_count = win_count;
    return r;
  endfunction

  function automatic dbra_pkg::result_t window(input logic rv, input logic [31:0] val,
                                               input logic [31:0] lo, input logic [31:0] hi,
                                               input logic [47:0] total,
                                               input logic [31:0] count);
    dbra_pkg::result_t r;
    r.report_valid = rv;
    r.report_value = val;
    r.window_min = lo;
    r.window_max = hi;
    r.window_total = total;
    r.sample_count = count;
    return r;
  endfunction

  function automatic plan_row_t request_row(input logic act, input logic [31:0] value,
                                            input logic [31:0] tick);
    plan_row_t row;
    row = '{ROW_REQUEST, act, value, tick, '0, 1'b0, '0};
    return row;
  endfunction

  function automatic plan_row_t checked_row(input logic act, input logic [31:0] value,
                                            input logic [31:0] tick,
                                            input dbra_pkg::result_t want);
    plan_row_t row;
    row = '{ROW_REQUEST, act, value, tick, '0, 1'b1, want};
    return row;
  endfunction

  function automatic plan_row_t register_row(input logic [dbra_pkg::IDX_W-1:0] idx,
                                             input logic [31:0] data);
    plan_row_t row;
    row = '{ROW_REGISTER, dbra_pkg::ACT_SAMPLE, data, '0, idx, 1'b0, '0};
    return row;
  endfunction

  task automatic send_request(input logic act, input logic [31:0] value, input logic [31:0] tick,
                              input bit typed, input dbra_pkg::result_t want);
    dbra_pkg::result_t predicted;
    int                gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= act;
    in_sample_value <= value;
    in_now_tick <= tick;
    do @(posedge clk); while (in_stall);
    predicted = next_window_result(act, value, tick);
    window_results_due.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (window_results_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // write then read back one register
  task automatic write_register(input logic [dbra_pkg::IDX_W-1:0] idx, input logic [31:0] data);
    logic [31:0] stored;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      dbra_pkg::REG_ABSOLUTE_MODE:    mode_absolute = data[0];
      dbra_pkg::REG_CHANGE_THRESHOLD: deadband = data;
      dbra_pkg::REG_RATE_LIMIT:       min_gap = data;
      default: ;
    endcase
    stored = (idx == dbra_pkg::REG_ABSOLUTE_MODE) ? {31'd0, data[0]} : data;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("register %0d readback %h, want %h", idx, prdata, stored);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    dbra_pkg::result_t seen;
    dbra_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen.report_valid = out_report_valid;
      seen.report_value = out_report_value;
      seen.window_min = out_window_min;
      seen.window_max = out_window_max;
      seen.window_total = out_window_total;
      seen.sample_count = out_sample_count;
      if (window_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected result at %0t", $realtime);
      end else begin
        want = window_results_due.pop_front();
        if (seen.report_valid !== want.report_valid || seen.report_value !== want.report_value ||
            seen.window_min !== want.window_min || seen.window_max !== want.window_max ||
            seen.window_total !== want.window_total ||
            seen.sample_count !== want.sample_count) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("result mismatch at %0t", $realtime);
            $display("  want rv=%b val=%h min=%h max=%h total=%h count=%h", want.report_valid,
                     want.report_value, want.window_min, want.window_max, want.window_total,
                     want.sample_count);
            $display("  got  rv=%b val=%h min=%h max=%h total=%h count=%h", seen.report_valid,
                     seen.report_value, seen.window_min, seen.window_max, seen.window_total,
                     seen.sample_count);
          end
        end
      end
    end
  end

  // receiver stall pattern; the mode changes after a random hold
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0]     tick_now;
    logic [31:0]     value;
    logic [31:0]     off;
    logic            act;
    longint unsigned mag;
    int              pick;

    // straight after reset: no threshold, so statistics only
    plan.push_back(checked_row(dbra_pkg::ACT_SAMPLE, 32'h7FFF_FFFF, 32'd0,
                               window(1'b0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      48'h0000_7FFF_FFFF, 1)));
    plan.push_back(checked_row(dbra_pkg::ACT_SAMPLE, 32'h8000_0000, 32'd1,
                               window(1'b0, '0, 32'h8000_0000, 32'h7FFF_FFFF,
                                      48'hFFFF_FFFF_FFFF, 2)));
    plan.push_back(checked_row(dbra_pkg::ACT_WINDOW_RESET, 32'h1234_5678, 32'd5,
                               window(1'b0, '0, 32'h8000_0000, 32'h7FFF_FFFF, '0, 0)));
    plan.push_back(checked_row(dbra_pkg::ACT_SAMPLE, 32'h0000_0000, 32'd6,
                               window(1'b0, '0, '0, '0, '0, 1)));
    // absolute deadband around one unit
    plan.push_back(register_row(dbra_pkg::REG_ABSOLUTE_MODE, 32'd1));
    plan.push_back(register_row(dbra_pkg::REG_CHANGE_THRESHOLD, 32'h0001_0000));
    plan.push_back(request_row(dbra_pkg::ACT_SAMPLE, 32'h0001_0000, 32'd7));
    plan.push_back(request_row(dbra_pkg::ACT_SAMPLE, 32'h0002_0000, 32'd8));
    plan.push_back(request_row(dbra_pkg::ACT_SAMPLE, 32'h0002_0001, 32'd9));
    // rate limit, too soon then just late enough
    plan.push_back(register_row(dbra_pkg::REG_RATE_LIMIT, 32'd10));
    plan.push_back(request_row(dbra_pkg::ACT_SAMPLE, 32'h7FFF_0000, 32'd15));
    plan.push_back(request_row(dbra_pkg::ACT_SAMPLE, 32'h7FFF_0000, 32'd20));
    plan.push_back(register_row(dbra_pkg::REG_RATE_LIMIT, 32'hFFFF_FFFF));
    plan.push_back(request_row(dbra_pkg::ACT_SAMPLE, 32'h8001_0000, 32'hFFFF_FFFF));
    // tick wraps past zero
    plan.push_back(register_row(dbra_pkg::REG_RATE_LIMIT, 32'd5));
    plan.push_back(request_row(dbra_pkg::ACT_SAMPLE, 32'h8000_0000, 32'd3));
    // percent mode, ten percent
    plan.push_back(register_row(dbra_pkg::REG_ABSOLUTE_MODE, 32'd0));
    plan.push_back(register_row(dbra_pkg::REG_CHANGE_THRESHOLD, 32'h000A_0000));
    plan.push_back(register_row(dbra_pkg::REG_RATE_LIMIT, 32'd0));
    plan.push_back(request_row(dbra_pkg::ACT_SAMPLE, 32'hC000_0000, 32'd4));
    plan.push_back(request_row(dbra_pkg::ACT_SAMPLE, 32'hC400_0000, 32'd5));
    plan.push_back(request_row(dbra_pkg::ACT_WINDOW_RESET, 32'hFFFF_FFFF, 32'd10));
    // last reported zero in percent mode
    plan.push_back(request_row(dbra_pkg::ACT_SAMPLE, 32'h0000_0000, 32'd11));
    plan.push_back(request_row(dbra_pkg::ACT_SAMPLE, 32'h0000_0000, 32'd12));
    plan.push_back(request_row(dbra_pkg::ACT_SAMPLE, 32'h0000_0001, 32'd13));
    // widest threshold in both modes
    plan.push_back(register_row(dbra_pkg::REG_CHANGE_THRESHOLD, 32'hFFFF_FFFF));
    plan.push_back(register_row(dbra_pkg::REG_ABSOLUTE_MODE, 32'd1));
    plan.push_back(request_row(dbra_pkg::ACT_SAMPLE, 32'h8000_0000, 32'd14));
    plan.push_back(request_row(dbra_pkg::ACT_SAMPLE, 32'hFFFF_FFFF, 32'd15));
    plan.push_back(register_row(dbra_pkg::REG_ABSOLUTE_MODE, 32'd0));
    plan.push_back(request_row(dbra_pkg::ACT_SAMPLE, 32'h7FFF_FFFF, 32'd16));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REGISTER) begin
        drain_results();
        write_register(plan[i].reg_idx, plan[i].value);
      end else begin
        send_request(plan[i].act, plan[i].value, plan[i].tick, plan[i].typed, plan[i].want);
      end
    end

    tick_now = 32'd100;

    for (int phase = 0; phase < 7; phase++) begin
      drain_results();
      write_register(dbra_pkg::REG_ABSOLUTE_MODE, 32'($urandom_range(0, 1)));
      case ($urandom_range(0, 5))
        0: off = 32'd0;
        1: off = 32'hFFFF_FFFF;
        2: off = $urandom_range(1, 32'h0004_0000);
        3: off = $urandom;
        4: off = $urandom_range(1, 32'h0064_0000);
        default: off = 32'h0001_0000;
      endcase
      write_register(dbra_pkg::REG_CHANGE_THRESHOLD, off);
      case ($urandom_range(0, 3))
        0: off = 32'd0;
        1: off = 32'hFFFF_FFFF;
        2: off = $urandom_range(0, 8);
        default: off = $urandom;
      endcase
      write_register(dbra_pkg::REG_RATE_LIMIT, off);
      if (phase == 2) tick_now = 32'hFFFF_FF00;
      for (int n = 0; n < 100; n++) begin
        act = dbra_pkg::ACT_SAMPLE;
        value = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          act = dbra_pkg::ACT_WINDOW_RESET;
        end else if (pick < 16) begin
          case ($urandom_range(0, 4))
            0: value = 32'h7FFF_FFFF;
            1: value = 32'h8000_0000;
            2: value = 32'h0000_0000;
            3: value = 32'hFFFF_FFFF;
            default: value = 32'h0000_0001;
          endcase
        end else if (pick < 36) begin
          value = $urandom;
        end else if (pick < 70) begin
          // just inside or just outside the deadband
          mag = (prev_value < 0) ? 64'(-longint'(prev_value)) : 64'(longint'(prev_value));
          off = mode_absolute ? deadband : 32'((mag * 64'(deadband)) / PCT_Q16);
          off = off + $urandom_range(0, 2) - 1;
          value = ($urandom_range(0, 1) == 0) ? prev_value + off : prev_value - off;
        end else begin
          value = prev_value + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        end
        case ($urandom_range(0, 9))
          0: tick_now = $urandom;
          1: ;
          2, 3: tick_now = prev_tick + min_gap + $urandom_range(0, 2) - 1;
          default: tick_now = tick_now + $urandom_range(1, 16);
        endcase
        send_request(act, value, tick_now, 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && window_results_due.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
